// ===== src/wsu_pkg.sv =====
package wsu_pkg;

  typedef logic [1:0] phase_t;

  // frame parser phases
  localparam phase_t PH_LEN  = 2'd0;
  localparam phase_t PH_EXT  = 2'd1;
  localparam phase_t PH_MASK = 2'd2;
  localparam phase_t PH_DATA = 2'd3;

  // length byte codes
  localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
  localparam logic [6:0] LEN_EXT16     = 7'd126;
  localparam logic [6:0] LEN_EXT64     = 7'd127;

  // header byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_BYTES  = 4'd4;

  // per-byte control from the frame parser to the output stage
  typedef struct packed {
    logic       emit;
    logic       last;
    logic [7:0] key_byte;
  } wsu_ctl_t;

endpackage

// ===== src/wsu_in_if.sv =====
interface wsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ===== src/wsu_out_if.sv =====
interface wsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== src/wsu_frame_ctl.sv =====
module wsu_frame_ctl
  import wsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  output wsu_ctl_t   ctl
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] remaining_r, remaining_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  idx_r, idx_nxt;

  logic [63:0] rem_dec;
  logic [3:0]  cnt_dec;
  logic [7:0]  key_byte;

  assign rem_dec = remaining_r - 64'd1;
  assign cnt_dec = cnt_r - 4'd1;

  always_comb begin
    case (idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign ctl.emit     = (phase_r == PH_DATA);
  assign ctl.last     = (rem_dec == 64'd0);
  assign ctl.key_byte = key_byte;

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    remaining_nxt = remaining_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    if (in_fire) begin
      case (phase_r)
        PH_LEN: begin
          if (in_byte[6:0] <= LEN_MAX_SHORT) begin
            remaining_nxt = {57'd0, in_byte[6:0]};
            phase_nxt     = PH_MASK;
            cnt_nxt       = MASK_BYTES;
            key_nxt       = 32'd0;
          end else begin
            remaining_nxt = 64'd0;
            phase_nxt     = PH_EXT;
            cnt_nxt       = (in_byte[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          end
        end
        PH_EXT: begin
          remaining_nxt = {remaining_r[55:0], in_byte};
          cnt_nxt       = cnt_dec;
          if (cnt_dec == 4'd0) begin
            phase_nxt = PH_MASK;
            cnt_nxt   = MASK_BYTES;
            key_nxt   = 32'd0;
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], in_byte};
          cnt_nxt = cnt_dec;
          if (cnt_dec == 4'd0) begin
            idx_nxt   = 2'd0;
            phase_nxt = (remaining_r == 64'd0) ? PH_LEN : PH_DATA;
          end
        end
        default: begin
          idx_nxt       = idx_r + 2'd1;
          remaining_nxt = rem_dec;
          if (rem_dec == 64'd0) begin
            phase_nxt = PH_LEN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEN;
      cnt_r       <= 4'd0;
      remaining_r <= 64'd0;
      key_r       <= 32'd0;
      idx_r       <= 2'd0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      remaining_r <= remaining_nxt;
      key_r       <= key_nxt;
      idx_r       <= idx_nxt;
    end
  end

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> remaining_r != 64'd0)
    else $error("payload phase with zero bytes remaining");

  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_MASK || phase_r == PH_EXT) |-> (cnt_r != 4'd0 && cnt_r <= EXT64_BYTES))
    else $error("header byte count out of range");

  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_DATA && remaining_r == 64'd1 |=> phase_r == PH_LEN)
    else $error("parser did not return to length byte after last payload byte");

endmodule

// ===== src/websocket_payload_unmasker.sv =====
// websocket client frame payload unmasker
//
// in_ch carries the raw frame byte stream, starting at each frame's
// mask-and-length byte (the opcode byte is not part of the stream). length,
// extended length (16 or 64 bit, big endian) and the four mask bytes are
// absorbed and give no output. each payload byte leaves on out_ch XORed with
// the mask byte for its position mod 4, with out_last set on the final one.
// a zero-length frame gives no output at all.
//
// throughput: one byte per cycle, header and payload alike, while in_ch.ready is high.
// latency: a payload byte shows on out_ch the cycle after its transfer,
// from a single output register.
// stall: in_ch.ready drops only while that output register is full and
// out_ch.ready is low; the receiver's ready is the one path from out to in.
// reset: synchronous, active low; the parser waits for a length byte and
// the output register is empty.
module websocket_payload_unmasker
  import wsu_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  wsu_in_if.sink   in_ch,
  wsu_out_if.source out_ch
);

  wsu_ctl_t   ctl;
  logic       in_fire;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  // take a new byte whenever the output register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // header parsing, length countdown and mask selection
  wsu_frame_ctl u_frame_ctl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_ch.in_byte),
    .ctl     (ctl)
  );

  // output register: loads on a payload byte transfer, empties on out transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (in_fire && ctl.emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = in_ch.in_byte ^ ctl.key_byte;
      out_last_nxt  = ctl.last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && ctl.emit |=> out_valid_r)
    else $error("payload byte transfer did not fill the output register");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_fire)
    else $error("input accepted while output register is stalled");

  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=>
      out_valid_r && $stable(out_byte_r) && $stable(out_last_r))
    else $error("stalled output changed before its transfer");

endmodule

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;
  import wsu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one unmasked payload byte as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } unmasked_t;

  logic clk = 1'b0;
  logic rst_n;

  wsu_in_if  in_ch ();
  wsu_out_if out_ch ();

  websocket_payload_unmasker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // frame parser shadow: tracks the header and payload walk of the stream
  // ---------------------------------------------------------------------
  phase_t      parse_phase = PH_LEN;
  logic [3:0]  hdr_left    = '0;
  logic [63:0] bytes_to_go = '0;
  logic [31:0] mask_key    = '0;
  logic [1:0]  key_pos     = '0;

  // payload bytes still owed by the block, oldest first
  unmasked_t unmasked_q[$];

  int mismatches = 0;

  // knobs shared by the stimulus and the receiver
  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;
  int hold_cycles  = 0;

  function automatic void begin_key_collect();
    parse_phase = PH_MASK;
    hdr_left    = MASK_BYTES;
    mask_key    = '0;
  endfunction

  // advance the shadow parser by one accepted byte, queue any payload result
  function automatic void predict_unmask(input logic [7:0] b);
    logic [7:0] key_byte;
    unmasked_t  res;
    case (parse_phase)
      PH_LEN: begin
        bytes_to_go = '0;
        // mask bit is ignored, only the low seven bits count
        if (b[6:0] <= LEN_MAX_SHORT) begin
          bytes_to_go = 64'(b[6:0]);
          begin_key_collect();
        end else begin
          parse_phase = PH_EXT;
          hdr_left    = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
        end
      end
      PH_EXT: begin
        // big endian, taken as is even with the top bit set
        bytes_to_go = {bytes_to_go[55:0], b};
        hdr_left    = hdr_left - 4'd1;
        if (hdr_left == '0) begin_key_collect();
      end
      PH_MASK: begin
        mask_key = {mask_key[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == '0) begin
          key_pos = '0;
          // zero length frame: straight back to the next length byte
          parse_phase = (bytes_to_go == '0) ? PH_LEN : PH_DATA;
        end
      end
      default: begin
        key_byte    = mask_key[31 - 8 * key_pos -: 8];
        key_pos     = key_pos + 2'd1;
        bytes_to_go = bytes_to_go - 64'd1;
        res.data    = b ^ key_byte;
        res.last    = (bytes_to_go == '0);
        if (res.last) parse_phase = PH_LEN;
        unmasked_q.push_back(res);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------

  // offer one byte from a falling edge, return at the rising edge of its transfer
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (src_idle_on && $urandom_range(99) < 36) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.in_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    predict_unmask(b);
  endtask

  // one complete frame header plus n_payload random payload bytes
  task automatic send_frame(input logic mask_bit, input logic [6:0] len_code,
                            input logic [63:0] len_val, input int n_payload);
    logic [31:0] key_val;
    key_val = $urandom;
    send_byte({mask_bit, len_code});
    if (len_code == LEN_EXT16) begin
      for (int i = 1; i >= 0; i--) send_byte(len_val[8 * i +: 8]);
    end else if (len_code > LEN_EXT16) begin
      for (int i = 7; i >= 0; i--) send_byte(len_val[8 * i +: 8]);
    end
    for (int i = 3; i >= 0; i--) send_byte(key_val[8 * i +: 8]);
    for (int i = 0; i < n_payload; i++) send_byte(8'($urandom));
  endtask

  // drop valid and wait for every owed byte, then wait out the settle count
  // so the single output register can settle
  task automatic wait_drained(input int settle);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (unmasked_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // zero length frame with all-ones key, a masked two byte frame that hits
  // both byte extremes, and a zero 16-bit extended length
  task automatic test_directed_frames();
    send_byte(8'h00);
    repeat (4) send_byte(8'hff);
    send_byte(8'h82);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'hff);
    send_byte(8'hff);
    send_byte({1'b0, LEN_EXT16});
    send_byte(8'h00);
    send_byte(8'h00);
    repeat (4) send_byte(8'($urandom));
    wait_drained(2);
  endtask

  // short length codes; the second half runs with no idling on either side
  task automatic test_short_frames();
    logic [6:0] len;
    int         pick;
    for (int i = 0; i < 20; i++) begin
      pick = $urandom_range(99);
      if (i == 0 || pick < 4)  len = LEN_MAX_SHORT;
      else if (pick < 14)      len = 7'd0;
      else                     len = 7'($urandom_range(12, 1));
      if (i == 10) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      send_frame(1'($urandom), len, '0, int'(len));
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    wait_drained(2);
  endtask

  // 16-bit extended lengths, the first zero and the rest up to 270 so the high byte can be live
  task automatic test_ext16_frames();
    logic [63:0] len;
    for (int i = 0; i < 4; i++) begin
      len = (i == 0) ? 64'd0 : 64'($urandom_range(270, 1));
      send_frame(1'($urandom), LEN_EXT16, len, int'(len));
    end
    wait_drained(2);
  endtask

  // 64-bit extended lengths, one of them zero
  task automatic test_ext64_frames();
    logic [63:0] len;
    for (int i = 0; i < 5; i++) begin
      len = (i == 0) ? 64'd0 : 64'($urandom_range(40, 1));
      send_frame(1'($urandom), LEN_EXT64, len, int'(len));
    end
    wait_drained(2);
  endtask

  // receiver holds off while the sender keeps offering, so the output
  // register fills and the input stalls; then the sender waits for a drain
  task automatic test_output_stall();
    @(negedge clk);
    hold_cycles = 300;
    send_frame(1'b1, 7'd40, '0, 40);
    send_frame(1'b0, 7'd3, '0, 3);
    wait_drained(2);
  endtask

  // raw random bytes; only length bytes are held to the short range so an
  // enormous extended length cannot swallow the rest of the run; the frame
  // in progress is finished so the next test starts at a length byte
  task automatic test_random_stream();
    logic [7:0] b;
    for (int i = 0; i < 100; i++) begin
      b = 8'($urandom);
      if (parse_phase == PH_LEN && b[6:0] > LEN_MAX_SHORT)
        b[6:0] = 7'($urandom_range(LEN_MAX_SHORT));
      send_byte(b);
    end
    while (parse_phase != PH_LEN) send_byte(8'($urandom));
    wait_drained(2);
  endtask

  // 64-bit length with the top bit set is taken unchecked; the frame can
  // never finish, so this runs last and only a few payload bytes follow
  task automatic test_unbounded_length();
    logic [63:0] len;
    len     = {32'($urandom), 32'($urandom)};
    len[63] = 1'b1;
    send_frame(1'b1, LEN_EXT64, len, 12);
    wait_drained(4);
  endtask

  // ---------------------------------------------------------------------
  // receiver: random ready, long hold-off counted down here
  // ---------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_cycles  = hold_cycles - 1;
      end else if (!sink_idle_on) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(99) >= 36);
      end
    end
  end

  // ---------------------------------------------------------------------
  // result check: every output transfer against the oldest owed byte
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    unmasked_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (unmasked_q.size() == 0) begin
        $error("unexpected output transfer: out_byte %h out_last %b",
               out_ch.out_byte, out_ch.out_last);
        mismatches++;
      end else begin
        want = unmasked_q.pop_front();
        if (out_ch.out_byte !== want.data) begin
          $error("out_byte: expected %h, actual %h", want.data, out_ch.out_byte);
          mismatches++;
        end
        if (out_ch.out_last !== want.last) begin
          $error("out_last: expected %b, actual %b", want.last, out_ch.out_last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_frames();
    test_short_frames();
    test_ext16_frames();
    test_ext64_frames();
    test_output_stall();
    test_random_stream();
    test_unbounded_length();

    // anything owed but never delivered counts against the run
    if (unmasked_q.size() != 0) begin
      $error("%0d payload bytes never left the block", unmasked_q.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("websocket_payload_unmasker regression: pass");
    end else begin
      $display("websocket_payload_unmasker regression: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("websocket_payload_unmasker regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
